[hw/rtl/assert_macros.svh]
// Assertion macros shared by the slot ring manager RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/dsrm_pkg.sv]
// Package for the DMA slot ring manager: payload and control types, opcodes,
// register map and default sizes. Depends on nothing.
package dsrm_pkg;

    localparam int SLOT_W        = 4;
    localparam int CFG_W         = 5;
    localparam int MAX_SLOTS_DEF = 16;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    localparam logic [CFG_W-1:0] DEPTH_RST = 5'd16;

    localparam logic [APB_ADDR_W-3:0] REG_RING_DEPTH = 1'b0;

    localparam logic [1:0] OP_ACQUIRE = 2'd0;
    localparam logic [1:0] OP_MARK    = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;
    localparam logic [1:0] OP_QUERY   = 2'd3;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [SLOT_W-1:0] slot;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_index;
        logic              overflow;
        logic              bad_index;
        logic [SLOT_W-1:0] head_index;
        logic              head_empty;
    } t_out_item;

    typedef struct packed {
        logic load_tok;
        logic shift;
        logic clr_head;
        logic set_slot;
    } t_cell_cmd;

    typedef struct packed {
        logic any_hit;
        logic head_full;
    } t_row_stat;

endpackage

[hw/rtl/dsrm_cell.sv]
// One slot of the ring: its full mark and the scan token, which it hands to
// the next cell. Depends on dsrm_pkg.
module dsrm_cell #(
    parameter int MAX_SLOTS = dsrm_pkg::MAX_SLOTS_DEF,
    parameter int IDX       = 0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dsrm_pkg::t_cell_cmd              i_cmd,
    input  logic [$clog2(MAX_SLOTS)-1:0]     i_head,
    input  logic [$clog2(MAX_SLOTS)-1:0]     i_slot,
    input  logic [$clog2(MAX_SLOTS+1)-1:0]   i_depth,
    input  logic                             i_tok,
    output logic                             o_tok,
    output logic                             o_tok_fwd,
    output logic                             o_tok_wrap,
    output logic                             o_hit,
    output logic                             o_head_full
);
    import dsrm_pkg::*;

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int DW = $clog2(MAX_SLOTS + 1);
    localparam logic [IW-1:0] MY_IDX   = IW'(IDX);
    localparam logic [DW-1:0] NEXT_POS = DW'(IDX + 1);

    logic r_full, n_full;
    logic r_tok, n_tok;
    logic w_sel_head;
    logic w_last;

    assign w_sel_head = (i_head == MY_IDX);
    assign w_last     = (NEXT_POS == i_depth);

    always_comb begin
        n_tok = r_tok;
        if (i_cmd.load_tok) begin
            n_tok = w_sel_head;
        end else if (i_cmd.shift) begin
            n_tok = i_tok;
        end
        n_full = r_full;
        if (i_cmd.clr_head && w_sel_head) begin
            n_full = 1'b0;
        end else if (i_cmd.set_slot && (i_slot == MY_IDX)) begin
            n_full = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_tok  <= 1'b0;
        end else begin
            r_full <= n_full;
            r_tok  <= n_tok;
        end
    end

    assign o_tok       = r_tok;
    assign o_tok_fwd   = r_tok && !w_last;
    assign o_tok_wrap  = r_tok && w_last;
    assign o_hit       = r_tok && !r_full;
    assign o_head_full = r_full && w_sel_head;

endmodule

[hw/rtl/dsrm_ctrl.sv]
// Sequencer of the slot ring manager: head pointer, scan position and count,
// operation decode and the result register. Depends on dsrm_pkg and
// assert_macros.svh.
`include "assert_macros.svh"

module dsrm_ctrl #(
    parameter int MAX_SLOTS = dsrm_pkg::MAX_SLOTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  dsrm_pkg::t_in_item               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output dsrm_pkg::t_out_item              o_out_data,
    input  logic [dsrm_pkg::CFG_W-1:0]       i_depth_cfg,
    output logic [$clog2(MAX_SLOTS+1)-1:0]   o_depth,
    output logic [$clog2(MAX_SLOTS)-1:0]     o_head,
    output logic [$clog2(MAX_SLOTS)-1:0]     o_slot,
    output dsrm_pkg::t_cell_cmd              o_cmd,
    input  dsrm_pkg::t_row_stat              i_stat
);
    import dsrm_pkg::*;

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int DW = $clog2(MAX_SLOTS + 1);
    localparam int CW = (DW > CFG_W) ? DW : CFG_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i,
                                                input logic [DW-1:0] d);
        logic [DW-1:0] inc;
        inc = DW'(i) + DW'(1);
        return (inc < d) ? inc[IW-1:0] : '0;
    endfunction

    function automatic logic [SLOT_W-1:0] to_field(input logic [IW-1:0] v);
        logic [IW+SLOT_W-1:0] t;
        t = {{SLOT_W{1'b0}}, v};
        return t[SLOT_W-1:0];
    endfunction

    logic [1:0]        r_state, n_state;
    logic [IW-1:0]     r_head, n_head;
    logic [IW-1:0]     r_pos, n_pos;
    logic [IW-1:0]     r_cnt, n_cnt;
    logic [1:0]        r_op, n_op;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [IW-1:0]     r_grant, n_grant;
    logic              r_ovf, n_ovf;
    logic              r_bad, n_bad;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out_data, n_out_data;

    logic [CW-1:0]     w_cfg_x;
    logic [CW-1:0]     w_depth_x;
    logic [DW-1:0]     w_depth;
    logic [IW-1:0]     w_head_eff;
    logic              w_out_free;
    t_cell_cmd         w_cmd;

    always_comb begin
        w_cfg_x = CW'(i_depth_cfg);
        if (w_cfg_x == '0) begin
            w_depth_x = CW'(1);
        end else if (w_cfg_x > CW'(MAX_SLOTS)) begin
            w_depth_x = CW'(MAX_SLOTS);
        end else begin
            w_depth_x = w_cfg_x;
        end
        w_depth = w_depth_x[DW-1:0];
    end

    assign w_head_eff = (DW'(r_head) >= w_depth) ? '0 : r_head;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_op        = r_op;
        n_slot      = r_slot;
        n_grant     = r_grant;
        n_ovf       = r_ovf;
        n_bad       = r_bad;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        w_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_in_data.opcode;
                    n_slot  = i_in_data.slot;
                    n_head  = w_head_eff;
                    n_grant = '0;
                    n_ovf   = 1'b0;
                    n_bad   = 1'b0;
                    if (i_in_data.opcode == OP_ACQUIRE) begin
                        w_cmd.load_tok = 1'b1;
                        n_pos          = w_head_eff;
                        n_cnt          = '0;
                        n_state        = ST_SCAN;
                    end else begin
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_SCAN: begin
                if (i_stat.any_hit) begin
                    n_grant = r_pos;
                    n_state = ST_FIN;
                end else if ((DW'(r_cnt) + DW'(1)) == w_depth) begin
                    w_cmd.clr_head = 1'b1;
                    n_grant        = r_head;
                    n_head         = ring_next(r_head, w_depth);
                    n_ovf          = 1'b1;
                    n_state        = ST_FIN;
                end else begin
                    w_cmd.shift = 1'b1;
                    n_pos       = ring_next(r_pos, w_depth);
                    n_cnt       = r_cnt + IW'(1);
                end
            end
            ST_EXEC: begin
                case (r_op)
                    OP_MARK: begin
                        if (CW'(r_slot) >= CW'(w_depth)) begin
                            n_bad = 1'b1;
                        end else begin
                            w_cmd.set_slot = 1'b1;
                        end
                    end
                    OP_RELEASE: begin
                        w_cmd.clr_head = 1'b1;
                        n_head         = ring_next(r_head, w_depth);
                    end
                    default: begin
                    end
                endcase
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_out_valid           = 1'b1;
                    n_out_data.slot_index = to_field(r_grant);
                    n_out_data.overflow   = r_ovf;
                    n_out_data.bad_index  = r_bad;
                    n_out_data.head_index = to_field(r_head);
                    n_out_data.head_empty = !i_stat.head_full;
                    n_state               = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_cnt      <= n_cnt;
        r_op       <= n_op;
        r_slot     <= n_slot;
        r_grant    <= n_grant;
        r_ovf      <= n_ovf;
        r_bad      <= n_bad;
        r_out_data <= n_out_data;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_depth     = w_depth;
    assign o_head      = (r_state == ST_IDLE) ? w_head_eff : r_head;
    assign o_slot      = IW'(r_slot);
    assign o_cmd       = w_cmd;

    `ASSERT_AT(a_scan_cnt_range, i_clk, i_rst_n, (r_state != ST_SCAN) || (DW'(r_cnt) < w_depth), "Scan count has reached the ring depth.")
    `ASSERT_AT(a_head_in_range, i_clk, i_rst_n, (r_state == ST_IDLE) || (DW'(r_head) < w_depth), "Head lies outside the ring while busy.")
    `ASSERT_NEXT(a_hit_ends_scan, i_clk, i_rst_n, (r_state == ST_SCAN) && i_stat.any_hit, r_state == ST_FIN, "A free slot did not end the scan.")
    `ASSERT_AT(a_flags_exclusive, i_clk, i_rst_n, !(r_out_valid && r_out_data.overflow && r_out_data.bad_index), "Overflow and bad index flagged together.")

endmodule

[hw/rtl/dma_slot_ring_manager_unit.sv]
// An acquire walks the scan token from the head cell by cell until it finds a free slot
// or has visited every cell of the ring; other operations pass an execute state. Each
// result is registered once the output is free, and only then is a new transaction accepted.
// Reset clears every full mark and the head, and sets the ring depth to 16.
// Depends on dsrm_pkg, dsrm_ctrl, dsrm_cell and assert_macros.svh.
`include "assert_macros.svh"

module dma_slot_ring_manager_unit #(
    parameter int MAX_SLOTS = dsrm_pkg::MAX_SLOTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  dsrm_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output dsrm_pkg::t_out_item                 o_out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dsrm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [dsrm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [dsrm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import dsrm_pkg::*;

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int DW = $clog2(MAX_SLOTS + 1);

    logic [CFG_W-1:0]     r_ring_depth;
    logic                 w_reg_sel;
    logic [DW-1:0]        w_depth;
    logic [IW-1:0]        w_head;
    logic [IW-1:0]        w_slot;
    t_cell_cmd            w_cmd;
    t_row_stat            w_stat;
    logic [MAX_SLOTS-1:0] w_tok;
    logic [MAX_SLOTS-1:0] w_tok_in;
    logic [MAX_SLOTS-1:0] w_fwd;
    logic [MAX_SLOTS-1:0] w_wrap;
    logic [MAX_SLOTS-1:0] w_hit;
    logic [MAX_SLOTS-1:0] w_hfull;

    assign w_reg_sel = (paddr[APB_ADDR_W-1:2] == REG_RING_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_depth <= DEPTH_RST;
        end else if (psel && penable && pwrite && w_reg_sel) begin
            r_ring_depth <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = w_reg_sel ? APB_DATA_W'(r_ring_depth) : '0;
    assign pready = 1'b1;

    dsrm_ctrl #(
        .MAX_SLOTS(MAX_SLOTS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_depth_cfg(r_ring_depth),
        .o_depth    (w_depth),
        .o_head     (w_head),
        .o_slot     (w_slot),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    assign w_tok_in[0] = |w_wrap;

    for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
        if (g > 0) begin : g_link
            assign w_tok_in[g] = w_fwd[g-1];
        end
        dsrm_cell #(
            .MAX_SLOTS(MAX_SLOTS),
            .IDX      (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (w_cmd),
            .i_head     (w_head),
            .i_slot     (w_slot),
            .i_depth    (w_depth),
            .i_tok      (w_tok_in[g]),
            .o_tok      (w_tok[g]),
            .o_tok_fwd  (w_fwd[g]),
            .o_tok_wrap (w_wrap[g]),
            .o_hit      (w_hit[g]),
            .o_head_full(w_hfull[g])
        );
    end

    assign w_stat.any_hit   = |w_hit;
    assign w_stat.head_full = |w_hfull;

    `ASSERT_AT(a_tok_single, i_clk, i_rst_n, $onehot0(w_tok), "More than one cell holds the scan token.")
    `ASSERT_AT(a_head_full_single, i_clk, i_rst_n, $onehot0(w_hfull), "More than one cell claims the head.")

endmodule

[tb/dma_slot_ring_manager_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for dma_slot_ring_manager_unit: drives ring operations and
// register writes, predicts each status transaction in a scoreboard and compares it.
// Depends on dsrm_pkg and the slot ring manager RTL.

class slot_ring_scoreboard;
    logic [dsrm_pkg::MAX_SLOTS_DEF-1:0] full_mark;
    int unsigned                        head;
    logic [dsrm_pkg::CFG_W-1:0]         depth_reg;
    dsrm_pkg::t_out_item                expected_status[$];
    int unsigned                        errors;

    function new();
        full_mark = '0;
        head = 0;
        depth_reg = dsrm_pkg::DEPTH_RST;
        errors = 0;
    endfunction

    function void set_depth(logic [dsrm_pkg::CFG_W-1:0] value);
        depth_reg = value;
    endfunction

    function int unsigned active_depth();
        if (depth_reg == 0) begin
            return 1;
        end
        if (depth_reg > dsrm_pkg::MAX_SLOTS_DEF) begin
            return dsrm_pkg::MAX_SLOTS_DEF;
        end
        return depth_reg;
    endfunction

    function int unsigned ring_next(int unsigned idx, int unsigned d);
        return (idx + 1 < d) ? idx + 1 : 0;
    endfunction

    function void predict_ring_op(dsrm_pkg::t_in_item item);
        int unsigned         d;
        int unsigned         idx;
        int unsigned         n;
        bit                  found;
        dsrm_pkg::t_out_item status;
        d = active_depth();
        status = '0;
        if (head >= d) begin
            head = 0;
        end
        case (item.opcode)
            dsrm_pkg::OP_ACQUIRE: begin
                idx = head;
                found = 1'b0;
                for (n = 0; n < d && !found; n++) begin
                    if (!full_mark[idx]) begin
                        found = 1'b1;
                    end else begin
                        idx = ring_next(idx, d);
                    end
                end
                if (found) begin
                    status.slot_index = idx[dsrm_pkg::SLOT_W-1:0];
                end else begin
                    status.slot_index = head[dsrm_pkg::SLOT_W-1:0];
                    full_mark[head] = 1'b0;
                    head = ring_next(head, d);
                    status.overflow = 1'b1;
                end
            end
            dsrm_pkg::OP_MARK: begin
                if (item.slot < d) begin
                    full_mark[item.slot] = 1'b1;
                end else begin
                    status.bad_index = 1'b1;
                end
            end
            dsrm_pkg::OP_RELEASE: begin
                full_mark[head] = 1'b0;
                head = ring_next(head, d);
            end
            default: begin
            end
        endcase
        status.head_index = head[dsrm_pkg::SLOT_W-1:0];
        status.head_empty = !full_mark[head];
        expected_status.push_back(status);
    endfunction

    function void compare_field(string name, logic [dsrm_pkg::SLOT_W-1:0] want,
                                logic [dsrm_pkg::SLOT_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_result(dsrm_pkg::t_out_item got);
        dsrm_pkg::t_out_item want;
        if (expected_status.size() == 0) begin
            $display("%0t: unexpected status transaction, expected none got %h", $time, got);
            errors++;
            return;
        end
        want = expected_status.pop_front();
        compare_field("slot_index", want.slot_index, got.slot_index);
        compare_field("overflow", 4'(want.overflow), 4'(got.overflow));
        compare_field("bad_index", 4'(want.bad_index), 4'(got.bad_index));
        compare_field("head_index", want.head_index, got.head_index);
        compare_field("head_empty", 4'(want.head_empty), 4'(got.head_empty));
    endfunction
endclass

module dma_slot_ring_manager_unit_tb;
    import dsrm_pkg::*;

    localparam int unsigned             LIMIT_CYCLES = 400000;
    localparam int unsigned             PHASE_ITEMS  = 200;
    localparam logic [APB_ADDR_W-1:0]   DEPTH_ADDR   = {REG_RING_DEPTH, 2'b00};

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    t_in_item               in_data = '0;
    logic                   out_ready = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    t_out_item              o_out_data;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    slot_ring_scoreboard    sb;
    bit                     idle_on = 1'b1;
    int unsigned            stall_left = 0;
    int unsigned            cycle_count = 0;
    logic [CFG_W-1:0]       phase_depth [10];

    dma_slot_ring_manager_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && o_in_ready) begin
                sb.predict_ring_op(in_data);
            end
            if (o_out_valid && out_ready) begin
                sb.check_result(o_out_data);
            end
            if (stall_left > 0) begin
                stall_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 5);
            end
            out_ready <= (stall_left == 0);
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [SLOT_W-1:0] idx);
        int unsigned gap;
        t_in_item    item;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        item.opcode = op;
        item.slot = idx;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_random();
        int unsigned      pick;
        int unsigned      d;
        logic [1:0]       op;
        logic [SLOT_W-1:0] idx;
        d = sb.active_depth();
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            op = OP_ACQUIRE;
        end else if (pick < 65) begin
            op = OP_MARK;
        end else if (pick < 85) begin
            op = OP_RELEASE;
        end else begin
            op = OP_QUERY;
        end
        if ($urandom_range(0, 4) == 0) begin
            idx = SLOT_W'($urandom);
        end else begin
            idx = SLOT_W'($urandom_range(0, d - 1));
        end
        send_item(op, idx);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_status.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_depth(input logic [CFG_W-1:0] value);
        logic [APB_DATA_W-1:0] rd;
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= DEPTH_ADDR;
        pwdata <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_depth(value);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd[CFG_W-1:0] !== value) begin
            $display("%0t: ring_depth readback expected %0d got %0d", $time, value,
                     rd[CFG_W-1:0]);
            sb.errors++;
        end
    endtask

    initial begin
        sb = new();
        phase_depth = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd7, 5'd3, 5'd12, 5'd16};
        phase_depth[6] = CFG_W'($urandom_range(1, 16));
        phase_depth[8] = CFG_W'($urandom_range(1, 16));
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(OP_QUERY, 4'd0);
        send_item(OP_ACQUIRE, 4'd0);
        drain();

        write_depth(5'd4);
        send_item(OP_QUERY, 4'd15);
        send_item(OP_ACQUIRE, 4'd15);
        send_item(OP_MARK, 4'd0);
        send_item(OP_MARK, 4'd1);
        send_item(OP_MARK, 4'd2);
        send_item(OP_MARK, 4'd3);
        send_item(OP_MARK, 4'd15);
        send_item(OP_MARK, 4'd4);
        send_item(OP_ACQUIRE, 4'd0);
        send_item(OP_ACQUIRE, 4'd0);
        repeat (6) send_item(OP_RELEASE, 4'd0);
        drain();

        write_depth(5'd2);
        send_item(OP_QUERY, 4'd0);
        drain();

        write_depth(5'd0);
        send_item(OP_ACQUIRE, 4'd0);
        send_item(OP_MARK, 4'd0);
        send_item(OP_MARK, 4'd1);
        send_item(OP_ACQUIRE, 4'd0);
        drain();

        write_depth(5'd31);
        send_item(OP_QUERY, 4'd0);
        send_item(OP_ACQUIRE, 4'd0);
        drain();

        for (int p = 0; p < 10; p++) begin
            write_depth(phase_depth[p]);
            if (p == 9) begin
                idle_on = 1'b0;
            end
            repeat (PHASE_ITEMS) send_random();
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_status.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
